FILE: rtl/core/ppi_pkg.sv
// Shared types, constants and fixed-point helpers of the particle pool integrator.
package ppi_pkg;

    localparam int SLOTS     = 256;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int CNT_W     = $clog2(SLOTS + 1);
    localparam int DIV_STEPS = 6;
    localparam int DIV_W     = $clog2(DIV_STEPS);

    localparam logic [6:0] ALPHA_FULL = 7'd64;

    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_SPAWN = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    localparam logic [2:0] CFG_DRAG_XY     = 3'd0;
    localparam logic [2:0] CFG_DRAG_Z      = 3'd1;
    localparam logic [2:0] CFG_SPAWN_SIZE  = 3'd2;
    localparam logic [2:0] CFG_SIZE_RATE   = 3'd3;
    localparam logic [2:0] CFG_SPAWN_SPIN  = 3'd4;
    localparam logic [2:0] CFG_SPIN_CHANGE = 3'd5;

    typedef logic signed [31:0] t_q;

    typedef struct packed {
        t_q [2:0]   pos;
        t_q [2:0]   vel;
        t_q         angle;
        t_q         spin;
        t_q         size;
        t_q         lifetime;
        t_q         life_left;
        logic [6:0] alpha;
    } t_slot;

    localparam int SLOT_BITS = $bits(t_slot);

    typedef enum logic [4:0] {
        S_IDLE,
        S_TPRE1,
        S_TPRE2,
        S_TCHK,
        S_TLOAD,
        S_TLIFE,
        S_TMVD,
        S_TMDT,
        S_TUPV,
        S_TMVDT,
        S_TUPP,
        S_TSPIN,
        S_TMANG,
        S_TANG,
        S_TALPHA,
        S_TDIV,
        S_TWB,
        S_SSCAN,
        S_RREAD,
        S_RLOAD,
        S_OUT
    } t_state;

    typedef struct packed {
        logic accept;
        logic pre_sc;
        logic pre_sr;
        logic ram_rd;
        logic load_slot;
        logic life;
        logic kill;
        logic mul_vd;
        logic mul_dt;
        logic upd_v;
        logic mul_vdt;
        logic upd_p;
        logic upd_spin;
        logic mul_sdt;
        logic upd_ang;
        logic alpha_init;
        logic div_step;
        logic write_back;
        logic spawn_write;
        logic idx_inc;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic alive_at_idx;
        logic idx_last;
        logic dead;
        logic axis_last;
        logic alpha_skip;
        logic div_last;
        logic full;
        logic out_free;
    } t_stat;

    function automatic t_q sat32(input logic signed [64:0] x);
        if (x > 65'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (x < -65'sd2147483648) begin
            return 32'sh80000000;
        end else begin
            return x[31:0];
        end
    endfunction

    // Product of two Q16.16 values, floored and saturated.
    function automatic t_q mulq(input t_q a, input logic signed [32:0] b);
        logic signed [64:0] p;
        p = 65'(a) * 65'(b);
        return sat32(p >>> 16);
    endfunction

    function automatic t_q addq(input t_q a, input t_q b);
        return sat32(65'(a) + 65'(b));
    endfunction

endpackage

FILE: rtl/core/ppi_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ppi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/ppi_ctrl.sv
// Sequencer of the particle pool integrator: request dispatch and per-slot update steps.
module ppi_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [1:0]       i_req_type,
    output logic             o_in_ready,
    input  ppi_pkg::t_stat   i_stat,
    output ppi_pkg::t_cmd    o_cmd
);

    ppi_pkg::t_state r_state;
    ppi_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ppi_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ppi_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_req_type)
                        ppi_pkg::REQ_TICK:  n_state = ppi_pkg::S_TPRE1;
                        ppi_pkg::REQ_SPAWN: n_state = i_stat.full ? ppi_pkg::S_OUT
                                                                  : ppi_pkg::S_SSCAN;
                        ppi_pkg::REQ_READ:  n_state = ppi_pkg::S_RREAD;
                        default:            n_state = ppi_pkg::S_OUT;
                    endcase
                end
            end
            ppi_pkg::S_TPRE1: n_state = ppi_pkg::S_TPRE2;
            ppi_pkg::S_TPRE2: n_state = ppi_pkg::S_TCHK;
            ppi_pkg::S_TCHK: begin
                if (i_stat.alive_at_idx) begin
                    n_state = ppi_pkg::S_TLOAD;
                end else if (i_stat.idx_last) begin
                    n_state = ppi_pkg::S_OUT;
                end
            end
            ppi_pkg::S_TLOAD: n_state = ppi_pkg::S_TLIFE;
            ppi_pkg::S_TLIFE: begin
                if (!i_stat.dead) begin
                    n_state = ppi_pkg::S_TMVD;
                end else if (i_stat.idx_last) begin
                    n_state = ppi_pkg::S_OUT;
                end else begin
                    n_state = ppi_pkg::S_TCHK;
                end
            end
            ppi_pkg::S_TMVD:  n_state = ppi_pkg::S_TMDT;
            ppi_pkg::S_TMDT:  n_state = ppi_pkg::S_TUPV;
            ppi_pkg::S_TUPV:  n_state = ppi_pkg::S_TMVDT;
            ppi_pkg::S_TMVDT: n_state = ppi_pkg::S_TUPP;
            ppi_pkg::S_TUPP:  n_state = i_stat.axis_last ? ppi_pkg::S_TSPIN : ppi_pkg::S_TMVD;
            ppi_pkg::S_TSPIN: n_state = ppi_pkg::S_TMANG;
            ppi_pkg::S_TMANG: n_state = ppi_pkg::S_TANG;
            ppi_pkg::S_TANG:  n_state = ppi_pkg::S_TALPHA;
            ppi_pkg::S_TALPHA: n_state = i_stat.alpha_skip ? ppi_pkg::S_TWB : ppi_pkg::S_TDIV;
            ppi_pkg::S_TDIV: begin
                if (i_stat.div_last) begin
                    n_state = ppi_pkg::S_TWB;
                end
            end
            ppi_pkg::S_TWB: n_state = i_stat.idx_last ? ppi_pkg::S_OUT : ppi_pkg::S_TCHK;
            ppi_pkg::S_SSCAN: begin
                if (!i_stat.alive_at_idx) begin
                    n_state = ppi_pkg::S_OUT;
                end
            end
            ppi_pkg::S_RREAD: n_state = ppi_pkg::S_RLOAD;
            ppi_pkg::S_RLOAD: n_state = ppi_pkg::S_OUT;
            ppi_pkg::S_OUT: begin
                if (i_stat.out_free) begin
                    n_state = ppi_pkg::S_IDLE;
                end
            end
            default: n_state = ppi_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ppi_pkg::S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            ppi_pkg::S_TPRE1: o_cmd.pre_sc = 1'b1;
            ppi_pkg::S_TPRE2: o_cmd.pre_sr = 1'b1;
            ppi_pkg::S_TCHK: begin
                o_cmd.ram_rd  = i_stat.alive_at_idx;
                o_cmd.idx_inc = !i_stat.alive_at_idx && !i_stat.idx_last;
            end
            ppi_pkg::S_TLOAD: o_cmd.load_slot = 1'b1;
            ppi_pkg::S_TLIFE: begin
                o_cmd.life    = !i_stat.dead;
                o_cmd.kill    = i_stat.dead;
                o_cmd.idx_inc = i_stat.dead && !i_stat.idx_last;
            end
            ppi_pkg::S_TMVD:   o_cmd.mul_vd   = 1'b1;
            ppi_pkg::S_TMDT:   o_cmd.mul_dt   = 1'b1;
            ppi_pkg::S_TUPV:   o_cmd.upd_v    = 1'b1;
            ppi_pkg::S_TMVDT:  o_cmd.mul_vdt  = 1'b1;
            ppi_pkg::S_TUPP:   o_cmd.upd_p    = 1'b1;
            ppi_pkg::S_TSPIN:  o_cmd.upd_spin = 1'b1;
            ppi_pkg::S_TMANG:  o_cmd.mul_sdt  = 1'b1;
            ppi_pkg::S_TANG:   o_cmd.upd_ang  = 1'b1;
            ppi_pkg::S_TALPHA: o_cmd.alpha_init = 1'b1;
            ppi_pkg::S_TDIV:   o_cmd.div_step = 1'b1;
            ppi_pkg::S_TWB: begin
                o_cmd.write_back = 1'b1;
                o_cmd.idx_inc    = !i_stat.idx_last;
            end
            ppi_pkg::S_SSCAN: begin
                o_cmd.spawn_write = !i_stat.alive_at_idx;
                o_cmd.idx_inc     = i_stat.alive_at_idx;
            end
            ppi_pkg::S_RREAD: o_cmd.ram_rd    = 1'b1;
            ppi_pkg::S_RLOAD: o_cmd.load_slot = 1'b1;
            ppi_pkg::S_OUT:   o_cmd.load_out  = i_stat.out_free;
            default: ;
        endcase
    end

endmodule

FILE: rtl/core/ppi_dp.sv
// Datapath of the particle pool integrator: slot store, shared multiplier, divider, outputs.
module ppi_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ppi_pkg::t_cmd         i_cmd,
    output ppi_pkg::t_stat        o_stat,
    input  logic                  i_cfg_valid,
    input  logic [2:0]            i_cfg_index,
    input  logic [31:0]           i_cfg_data,
    input  logic [1:0]            i_req_type,
    input  logic [31:0]           i_now_time,
    input  logic [7:0]            i_slot_index,
    input  logic signed [31:0]    i_start_x,
    input  logic signed [31:0]    i_start_y,
    input  logic signed [31:0]    i_start_z,
    input  logic signed [31:0]    i_speed_x,
    input  logic signed [31:0]    i_speed_y,
    input  logic signed [31:0]    i_speed_z,
    input  logic [30:0]           i_life_span,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic                  o_accepted,
    output logic [7:0]            o_slot_used,
    output logic                  o_is_alive,
    output logic signed [31:0]    o_out_x,
    output logic signed [31:0]    o_out_y,
    output logic signed [31:0]    o_out_z,
    output logic signed [31:0]    o_out_angle,
    output logic signed [31:0]    o_out_size,
    output logic [6:0]            o_out_alpha,
    output logic [8:0]            o_live_count
);

    ppi_pkg::t_q r_drag_xy;
    ppi_pkg::t_q r_drag_z;
    ppi_pkg::t_q r_spawn_size;
    ppi_pkg::t_q r_size_rate;
    ppi_pkg::t_q r_spawn_spin;
    ppi_pkg::t_q r_spin_change;

    logic [31:0]                   r_last;
    logic signed [32:0]            r_dt;
    logic [ppi_pkg::CNT_W-1:0]     r_total;
    logic [ppi_pkg::SLOTS-1:0]     r_alive;
    logic [ppi_pkg::SLOT_W-1:0]    r_idx;
    logic [1:0]                    r_axis;
    logic [ppi_pkg::DIV_W-1:0]     r_div_cnt;
    logic [31:0]                   r_rem;
    logic [5:0]                    r_quo;
    ppi_pkg::t_q                   r_mul;
    ppi_pkg::t_q                   r_scdt;
    ppi_pkg::t_q                   r_srdt;
    ppi_pkg::t_slot                r_slot;
    logic [1:0]                    r_req;
    logic                          r_read_ok;
    logic                          r_ok;
    ppi_pkg::t_q [2:0]             r_sp_pos;
    ppi_pkg::t_q [2:0]             r_sp_vel;
    logic [30:0]                   r_life_span;

    logic                          r_out_valid;
    logic                          r_o_accepted;
    logic [7:0]                    r_o_slot;
    logic                          r_o_alive;
    ppi_pkg::t_q                   r_o_x;
    ppi_pkg::t_q                   r_o_y;
    ppi_pkg::t_q                   r_o_z;
    ppi_pkg::t_q                   r_o_angle;
    ppi_pkg::t_q                   r_o_size;
    logic [6:0]                    r_o_alpha;
    logic [8:0]                    r_o_live;

    ppi_pkg::t_q                   vel_k;
    ppi_pkg::t_q                   drag_k;
    ppi_pkg::t_q                   mul_a;
    logic signed [32:0]            mul_b;
    ppi_pkg::t_q                   mul_res;
    logic signed [64:0]            left;
    ppi_pkg::t_q                   left_sat;
    logic                          alpha_skip;
    logic [32:0]                   rem2;
    logic [32:0]                   life_ext;
    logic                          rem_ge;
    logic [31:0]                   rem_nx;
    logic [5:0]                    quo_nx;
    ppi_pkg::t_slot                wslot;
    logic [ppi_pkg::SLOT_BITS-1:0] ram_rdata;
    logic                          ram_we;

    assign vel_k  = r_slot.vel[r_axis];
    assign drag_k = (r_axis == 2'd2) ? r_drag_z : r_drag_xy;

    // One multiplier shared by every product of the update.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (i_cmd.pre_sc) begin
            mul_a = r_spin_change;
            mul_b = r_dt;
        end else if (i_cmd.pre_sr) begin
            mul_a = r_size_rate;
            mul_b = r_dt;
        end else if (i_cmd.mul_vd) begin
            mul_a = vel_k;
            mul_b = 33'(drag_k);
        end else if (i_cmd.mul_dt) begin
            mul_a = r_mul;
            mul_b = r_dt;
        end else if (i_cmd.mul_vdt) begin
            mul_a = vel_k;
            mul_b = r_dt;
        end else if (i_cmd.mul_sdt) begin
            mul_a = r_slot.spin;
            mul_b = r_dt;
        end
    end

    assign mul_res = ppi_pkg::mulq(mul_a, mul_b);

    assign left       = 65'(r_slot.life_left) - 65'(r_dt);
    assign left_sat   = ppi_pkg::sat32(left);
    assign alpha_skip = (r_slot.lifetime <= 32'sd0) || (r_slot.life_left >= r_slot.lifetime);

    // Restoring division of 64*left by the lifetime, one quotient bit per cycle.
    assign rem2     = {r_rem, 1'b0};
    assign life_ext = {1'b0, r_slot.lifetime};
    assign rem_ge   = rem2 >= life_ext;
    assign rem_nx   = rem_ge ? 32'(rem2 - life_ext) : rem2[31:0];
    assign quo_nx   = {r_quo[4:0], rem_ge};

    always_comb begin
        wslot = r_slot;
        if (i_cmd.spawn_write) begin
            wslot.pos       = r_sp_pos;
            wslot.vel       = r_sp_vel;
            wslot.angle     = '0;
            wslot.spin      = r_spawn_spin;
            wslot.size      = r_spawn_size;
            wslot.lifetime  = {1'b0, r_life_span};
            wslot.life_left = {1'b0, r_life_span};
            wslot.alpha     = ppi_pkg::ALPHA_FULL;
        end else if (i_cmd.kill) begin
            wslot.life_left = left_sat;
        end
    end

    assign ram_we = i_cmd.spawn_write || i_cmd.kill || i_cmd.write_back;

    ppi_ram #(
        .WIDTH(ppi_pkg::SLOT_BITS),
        .DEPTH(ppi_pkg::SLOTS)
    ) u_slot_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_idx),
        .i_wdata(wslot),
        .i_re   (i_cmd.ram_rd),
        .i_raddr(r_idx),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drag_xy     <= -32'sd91750;
            r_drag_z      <= -32'sd65536;
            r_spawn_size  <= 32'sd1310720;
            r_size_rate   <= 32'sd3276800;
            r_spawn_spin  <= 32'sd16384;
            r_spin_change <= -32'sd16384;
            r_last        <= '0;
            r_total       <= '0;
            r_alive       <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    ppi_pkg::CFG_DRAG_XY:     r_drag_xy     <= i_cfg_data;
                    ppi_pkg::CFG_DRAG_Z:      r_drag_z      <= i_cfg_data;
                    ppi_pkg::CFG_SPAWN_SIZE:  r_spawn_size  <= i_cfg_data;
                    ppi_pkg::CFG_SIZE_RATE:   r_size_rate   <= i_cfg_data;
                    ppi_pkg::CFG_SPAWN_SPIN:  r_spawn_spin  <= i_cfg_data;
                    ppi_pkg::CFG_SPIN_CHANGE: r_spin_change <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.accept && (i_req_type == ppi_pkg::REQ_TICK)) begin
                r_last <= i_now_time;
            end
            if (i_cmd.kill) begin
                r_alive[r_idx] <= 1'b0;
                if (r_total != '0) begin
                    r_total <= r_total - ppi_pkg::CNT_W'(1);
                end
            end
            if (i_cmd.spawn_write) begin
                r_alive[r_idx] <= 1'b1;
                r_total        <= r_total + ppi_pkg::CNT_W'(1);
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req       <= i_req_type;
            r_dt        <= $signed({1'b0, i_now_time}) - $signed({1'b0, r_last});
            r_sp_pos    <= {i_start_z, i_start_y, i_start_x};
            r_sp_vel    <= {i_speed_z, i_speed_y, i_speed_x};
            r_life_span <= i_life_span;
            r_ok        <= 1'b0;
            r_read_ok   <= 32'(i_slot_index) < ppi_pkg::SLOTS;
            r_idx       <= (i_req_type == ppi_pkg::REQ_READ) ?
                           ppi_pkg::SLOT_W'(i_slot_index) : '0;
        end
        if (i_cmd.idx_inc) begin
            r_idx <= r_idx + ppi_pkg::SLOT_W'(1);
        end
        if (i_cmd.spawn_write) begin
            r_ok <= 1'b1;
        end
        if (i_cmd.pre_sc) begin
            r_scdt <= mul_res;
        end
        if (i_cmd.pre_sr) begin
            r_srdt <= mul_res;
        end
        if (i_cmd.mul_vd || i_cmd.mul_dt || i_cmd.mul_vdt || i_cmd.mul_sdt) begin
            r_mul <= mul_res;
        end
        if (i_cmd.load_slot) begin
            r_slot <= ppi_pkg::t_slot'(ram_rdata);
        end
        if (i_cmd.life) begin
            r_slot.life_left <= left_sat;
            r_axis           <= '0;
        end
        if (i_cmd.upd_v) begin
            r_slot.vel[r_axis] <= ppi_pkg::addq(vel_k, r_mul);
        end
        if (i_cmd.upd_p) begin
            r_slot.pos[r_axis] <= ppi_pkg::addq(r_slot.pos[r_axis], r_mul);
            r_axis             <= r_axis + 2'd1;
        end
        if (i_cmd.upd_spin) begin
            r_slot.spin <= ppi_pkg::addq(r_slot.spin, r_scdt);
            r_slot.size <= ppi_pkg::addq(r_slot.size, r_srdt);
        end
        if (i_cmd.upd_ang) begin
            r_slot.angle <= ppi_pkg::addq(r_slot.angle, r_mul);
        end
        if (i_cmd.alpha_init) begin
            if (alpha_skip) begin
                r_slot.alpha <= ppi_pkg::ALPHA_FULL;
            end
            r_rem     <= r_slot.life_left;
            r_quo     <= '0;
            r_div_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem     <= rem_nx;
            r_quo     <= quo_nx;
            r_div_cnt <= r_div_cnt + ppi_pkg::DIV_W'(1);
            if (r_div_cnt == ppi_pkg::DIV_W'(ppi_pkg::DIV_STEPS - 1)) begin
                r_slot.alpha <= {1'b0, quo_nx};
            end
        end
        if (i_cmd.load_out) begin
            r_o_accepted <= 1'b0;
            r_o_slot     <= '0;
            r_o_alive    <= 1'b0;
            r_o_x        <= '0;
            r_o_y        <= '0;
            r_o_z        <= '0;
            r_o_angle    <= '0;
            r_o_size     <= '0;
            r_o_alpha    <= '0;
            r_o_live     <= 9'(r_total);
            case (r_req)
                ppi_pkg::REQ_TICK: begin
                    r_o_accepted <= 1'b1;
                end
                ppi_pkg::REQ_SPAWN: begin
                    r_o_accepted <= r_ok;
                    r_o_slot     <= r_ok ? 8'(r_idx) : 8'd0;
                end
                ppi_pkg::REQ_READ: begin
                    if (r_read_ok) begin
                        r_o_accepted <= 1'b1;
                        r_o_slot     <= 8'(r_idx);
                        r_o_alive    <= r_alive[r_idx];
                        r_o_x        <= r_slot.pos[0];
                        r_o_y        <= r_slot.pos[1];
                        r_o_z        <= r_slot.pos[2];
                        r_o_angle    <= r_slot.angle;
                        r_o_size     <= r_slot.size;
                        r_o_alpha    <= r_slot.alpha;
                    end
                end
                default: begin
                    r_o_live <= '0;
                end
            endcase
        end
    end

    assign o_stat.alive_at_idx = r_alive[r_idx];
    assign o_stat.idx_last     = r_idx == ppi_pkg::SLOT_W'(ppi_pkg::SLOTS - 1);
    assign o_stat.dead         = left <= 65'sd0;
    assign o_stat.axis_last    = r_axis == 2'd2;
    assign o_stat.alpha_skip   = alpha_skip;
    assign o_stat.div_last     = r_div_cnt == ppi_pkg::DIV_W'(ppi_pkg::DIV_STEPS - 1);
    assign o_stat.full         = 32'(r_total) >= ppi_pkg::SLOTS;
    assign o_stat.out_free     = !r_out_valid || i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_accepted   = r_o_accepted;
    assign o_slot_used  = r_o_slot;
    assign o_is_alive   = r_o_alive;
    assign o_out_x      = r_o_x;
    assign o_out_y      = r_o_y;
    assign o_out_z      = r_o_z;
    assign o_out_angle  = r_o_angle;
    assign o_out_size   = r_o_size;
    assign o_out_alpha  = r_o_alpha;
    assign o_live_count = r_o_live;

endmodule

FILE: rtl/core/particle_pool_integrator.sv
// Top level of the particle pool integrator: sequencer plus datapath.
//
// A pool of 256 Q16.16 particles advanced by a semi-implicit Euler step. Each
// request is a single transfer on the input channel and yields exactly one
// transfer on the output channel; one request is in work at a time, and the next
// is taken as soon as the previous result sits in the output register. A spawn
// scans the alive flags one slot per cycle for the lowest free slot. A tick visits
// every slot in turn, and each live slot goes through one read-modify-write of
// the slot memory with all of its products on a single shared multiplier and its
// alpha from a bit-serial divider.
// Configuration writes are accepted in every cycle.
module particle_pool_integrator (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [2:0]            i_cfg_index,
    input  logic [31:0]           i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [1:0]            i_req_type,
    input  logic [31:0]           i_now_time,
    input  logic [7:0]            i_slot_index,
    input  logic signed [31:0]    i_start_x,
    input  logic signed [31:0]    i_start_y,
    input  logic signed [31:0]    i_start_z,
    input  logic signed [31:0]    i_speed_x,
    input  logic signed [31:0]    i_speed_y,
    input  logic signed [31:0]    i_speed_z,
    input  logic [30:0]           i_life_span,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_accepted,
    output logic [7:0]            o_slot_used,
    output logic                  o_is_alive,
    output logic signed [31:0]    o_out_x,
    output logic signed [31:0]    o_out_y,
    output logic signed [31:0]    o_out_z,
    output logic signed [31:0]    o_out_angle,
    output logic signed [31:0]    o_out_size,
    output logic [6:0]            o_out_alpha,
    output logic [8:0]            o_live_count
);

    ppi_pkg::t_cmd  cmd;
    ppi_pkg::t_stat stat;

    assign o_cfg_ready = 1'b1;

    ppi_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .i_req_type(i_req_type),
        .o_in_ready(o_in_ready),
        .i_stat    (stat),
        .o_cmd     (cmd)
    );

    ppi_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_req_type  (i_req_type),
        .i_now_time  (i_now_time),
        .i_slot_index(i_slot_index),
        .i_start_x   (i_start_x),
        .i_start_y   (i_start_y),
        .i_start_z   (i_start_z),
        .i_speed_x   (i_speed_x),
        .i_speed_y   (i_speed_y),
        .i_speed_z   (i_speed_z),
        .i_life_span (i_life_span),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_accepted  (o_accepted),
        .o_slot_used (o_slot_used),
        .o_is_alive  (o_is_alive),
        .o_out_x     (o_out_x),
        .o_out_y     (o_out_y),
        .o_out_z     (o_out_z),
        .o_out_angle (o_out_angle),
        .o_out_size  (o_out_size),
        .o_out_alpha (o_out_alpha),
        .o_live_count(o_live_count)
    );

endmodule

FILE: rtl/core/ppi_checker.sv
// Port-level checks of the particle pool integrator and their binding to the top level.
module ppi_props (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic       o_accepted,
    input logic [7:0] o_slot_used,
    input logic       o_is_alive,
    input logic [8:0] o_live_count
);

    // No result may be pending right after reset.
    a_idle_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before its transfer");

    // A refused request never names a slot or a live particle.
    a_refused_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_accepted |-> o_slot_used == 8'd0 && !o_is_alive)
        else $error("refused request carries slot data");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_live_count <= 9'd256)
        else $error("live count beyond pool size");

endmodule

bind particle_pool_integrator ppi_props u_ppi_props (.*);
